@@ src/thermistor_beta_temperature_core_assert.svh @@
// Assertion macros used by the thermistor temperature core RTL.
`ifndef THERMISTOR_BETA_TEMPERATURE_CORE_ASSERT_SVH
`define THERMISTOR_BETA_TEMPERATURE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/tbt_pkg.sv @@
// Constants, types and tables of the thermistor temperature pipeline.
`default_nettype none
package tbt_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int B_W          = 14;
  localparam int RD_W         = 20;
  localparam int RN_W         = 20;
  localparam int C_W          = 16;
  localparam int TEMP_W       = 15;
  localparam int QBITS        = 15;
  localparam int LN2_Q16      = 45426;

  localparam logic [B_W-1:0]  BETA_RST = 14'd3950;
  localparam logic [RD_W-1:0] RDIV_RST = 20'd10000;
  localparam logic [RN_W-1:0] RNOM_RST = 20'd10000;
  localparam logic [C_W-1:0]  TNOM_RST = 16'd29815;

  localparam logic [TEMP_W-1:0] TEMP_MAX = 15'h3FFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 15'h6000;
  localparam logic [QBITS-1:0]  QPOS_MAX = 15'd16383;
  localparam logic [QBITS-1:0]  QNEG_MAX = 15'd8192;

  typedef enum logic [1:0] {
    REG_BETA = 2'd0,
    REG_RDIV = 2'd1,
    REG_RNOM = 2'd2,
    REG_TNOM = 2'd3
  } reg_addr_e;

  typedef struct packed {
    logic vld;
    logic sp;
    logic np;
    logic neg;
    logic ovf;
  } ctl_t;

  function automatic int ln_width(input int xw);
    return $clog2(xw * LN2_Q16 + 1);
  endfunction

  // round(65536 * ln(1 + i/16))
  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:  r = 16'd0;
      5'd1:  r = 16'd3973;
      5'd2:  r = 16'd7719;
      5'd3:  r = 16'd11262;
      5'd4:  r = 16'd14624;
      5'd5:  r = 16'd17821;
      5'd6:  r = 16'd20870;
      5'd7:  r = 16'd23783;
      5'd8:  r = 16'd26573;
      5'd9:  r = 16'd29248;
      5'd10: r = 16'd31818;
      5'd11: r = 16'd34292;
      5'd12: r = 16'd36675;
      5'd13: r = 16'd38975;
      5'd14: r = 16'd41196;
      5'd15: r = 16'd43345;
      5'd16: r = 16'd45426;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/thermistor_beta_temperature_core.sv @@
// Top level: register port and fixed-point Beta-equation temperature pipeline.
//
// Usage: pulse start with a converter code on adc_code_i; busy is always
// low, so a new code may be started in every cycle. Each code yields one
// result on temp_f_sixteenths_o / out_of_range_o, shown for one cycle with
// valid_o high, in the order the codes went in.
// Throughput is one code per cycle. The pipeline is a product stage, a
// three-stage logarithm unit, six stages of wide products and sums, a
// fifteen-stage restoring divider, one quotient bit a stage, and an
// output register.
// The receiver cannot stall: results are not held back.
// Configuration goes through the APB-style port; write it only while no
// code is in flight. Reset clears the valid bits of every stage and loads
// the registers with their nominal values (Beta 3950 K, 10 kohm, 298.15 K).
// Codes zero and full scale give -8192 with out_of_range_o set; results out
// of range saturate and set out_of_range_o.
`default_nettype none
`include "thermistor_beta_temperature_core_assert.svh"
module thermistor_beta_temperature_core import tbt_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [ADC_BITS-1:0]      adc_code_i,
  output logic                     valid_o,
  output logic signed [TEMP_W-1:0] temp_f_sixteenths_o,
  output logic                     out_of_range_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int XW      = RD_W + ADC_BITS;
  localparam int LN_W    = ln_width(XW);
  localparam int D_W     = LN_W + 1;
  localparam int CD_W    = C_W + 1 + D_W;
  localparam int B100_W  = B_W + 23;
  localparam int DEN_W   = ((CD_W > B100_W + 1) ? CD_W : B100_W + 1) + 1;
  localparam int CB_W    = B_W + C_W;
  localparam int P1_W    = CB_W + 15;
  localparam int P2_W    = DEN_W + 21;
  localparam int NUM_W   = ((P1_W + 17 > P2_W) ? P1_W + 17 : P2_W) + 1;
  localparam int DV_W    = DEN_W + 10;
  localparam int HALF_W  = DEN_W + 9;
  localparam int A_W     = NUM_W + 1;
  localparam int CMP_W   = ((A_W > DV_W + QBITS + 1) ? A_W : DV_W + QBITS + 1) + 1;

  localparam int S_P     = 7;
  localparam int S_A     = 9;
  localparam int S_DIV   = 10;
  localparam int NST     = S_DIV + QBITS;

  localparam logic [22:0]             K_B100 = 23'd6553600;
  localparam logic [14:0]             K_P1   = 15'd28800;
  localparam logic signed [20:0]      K_P2   = 21'sd735472;
  localparam logic [9:0]              K_DV   = 10'd1000;
  localparam logic [8:0]              K_HALF = 9'd500;

  // configuration registers
  logic [B_W-1:0]  beta_q;
  logic [RD_W-1:0] rdiv_q;
  logic [RN_W-1:0] rnom_q;
  logic [C_W-1:0]  tnom_q;
  logic            cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RST;
      rdiv_q <= RDIV_RST;
      rnom_q <= RNOM_RST;
      tnom_q <= TNOM_RST;
    end else if (cfg_wr) begin
      case (reg_addr_e'(paddr[3:2]))
        REG_BETA: beta_q <= pwdata[B_W-1:0];
        REG_RDIV: rdiv_q <= pwdata[RD_W-1:0];
        REG_RNOM: rnom_q <= pwdata[RN_W-1:0];
        REG_TNOM: tnom_q <= pwdata[C_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_addr_e'(paddr[3:2]))
      REG_BETA: prdata = 32'(beta_q);
      REG_RDIV: prdata = 32'(rdiv_q);
      REG_RNOM: prdata = 32'(rnom_q);
      REG_TNOM: prdata = 32'(tnom_q);
      default:  prdata = '0;
    endcase
  end

  // zero Beta and resistor registers count as one
  logic [B_W-1:0]  beta_e;
  logic [RD_W-1:0] rdiv_e;
  logic [RN_W-1:0] rnom_e;

  assign beta_e = (beta_q == '0) ? B_W'(1) : beta_q;
  assign rdiv_e = (rdiv_q == '0) ? RD_W'(1) : rdiv_q;
  assign rnom_e = (rnom_q == '0) ? RN_W'(1) : rnom_q;

  // control travelling with the data
  ctl_t ctl_q [NST];
  ctl_t ctl_p, ctl_a, ctl_v;
  logic special;
  logic np_d;
  logic ovf_d;

  assign special = (adc_code_i == '0) || (adc_code_i == {ADC_BITS{1'b1}});

  // stage 0: resistor products
  logic [XW-1:0]       x_q, y_q;
  logic [ADC_BITS-1:0] code_inv;

  assign code_inv = ~adc_code_i;

  always_ff @(posedge clk_i) begin
    x_q <= XW'(rdiv_e) * XW'(adc_code_i);
    y_q <= XW'(rnom_e) * XW'(code_inv);
  end

  // stages 1 to 3: logarithms
  logic [LN_W-1:0] bx, by;
  logic [11:0]     fx, fy;

  tbt_ln #(.XW(XW)) u_ln_x (
    .clk_i  (clk_i),
    .v_i    (x_q),
    .base_o (bx),
    .frac_o (fx)
  );

  tbt_ln #(.XW(XW)) u_ln_y (
    .clk_i  (clk_i),
    .v_i    (y_q),
    .base_o (by),
    .frac_o (fy)
  );

  // stages 4 to 9: Beta equation and Fahrenheit scaling
  logic signed [D_W-1:0]    d_q;
  logic signed [CD_W-1:0]   cd_q;
  logic [B100_W-1:0]        b100_q;
  logic [CB_W-1:0]          cb_q, cb6_q;
  logic signed [DEN_W-1:0]  den_q;
  logic [P1_W-1:0]          p1_q;
  logic signed [P2_W-1:0]   p2_q;
  logic [DV_W-1:0]          dv7_q, dv8_q, dv9_q;
  logic [HALF_W-1:0]        half7_q, half8_q;
  logic signed [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]         mag;
  logic [A_W-1:0]           a_q;

  assign np_d = den_q[DEN_W-1] || (den_q == '0);
  assign mag  = num_q[NUM_W-1] ? (~num_q + 1'b1) : num_q;

  always_ff @(posedge clk_i) begin
    d_q     <= D_W'(bx + LN_W'(fx)) - D_W'(by + LN_W'(fy));
    cd_q    <= $signed({1'b0, tnom_q}) * d_q;
    b100_q  <= B100_W'(beta_e) * K_B100;
    cb_q    <= CB_W'(tnom_q) * CB_W'(beta_e);
    den_q   <= $signed({1'b0, b100_q}) + cd_q;
    cb6_q   <= cb_q;
    p1_q    <= P1_W'(cb6_q) * K_P1;
    p2_q    <= den_q * K_P2;
    dv7_q   <= DV_W'(den_q) * K_DV;
    half7_q <= HALF_W'(den_q) * K_HALF;
    num_q   <= $signed({1'b0, p1_q, 16'b0}) - p2_q;
    dv8_q   <= dv7_q;
    half8_q <= half7_q;
    a_q     <= A_W'(mag) + A_W'(half8_q);
    dv9_q   <= dv8_q;
  end

  // stages 10 to 24: restoring division, one quotient bit a stage
  logic [A_W-1:0]   rem_q [QBITS];
  logic [QBITS-1:0] qv_q  [QBITS];
  logic [DV_W-1:0]  dvs_q [QBITS-1];

  assign ovf_d = CMP_W'(a_q) >= (CMP_W'(dv9_q) << QBITS);

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int K = QBITS - 1 - j;
    logic [A_W-1:0]   rin;
    logic [DV_W-1:0]  din;
    logic [QBITS-1:0] qin;
    logic [CMP_W-1:0] sh;
    logic             ge;

    if (j == 0) begin : g_first
      assign rin = a_q;
      assign din = dv9_q;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign din = dvs_q[j-1];
      assign qin = qv_q[j-1];
    end

    assign sh = CMP_W'(din) << K;
    assign ge = CMP_W'(rin) >= sh;

    always_ff @(posedge clk_i) begin
      rem_q[j] <= ge ? (rin - A_W'(sh)) : rin;
      qv_q[j]  <= qin | (QBITS'(ge) << K);
    end

    if (j < QBITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        dvs_q[j] <= din;
      end
    end
  end

  // merge the flags that are found part way down the pipe
  always_comb begin
    ctl_p     = ctl_q[S_P-1];
    ctl_p.np  = np_d;
    ctl_a     = ctl_q[S_A-1];
    ctl_a.neg = num_q[NUM_W-1];
    ctl_v     = ctl_q[S_DIV-1];
    ctl_v.ovf = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      ctl_q[0] <= '{vld: start, sp: special, np: 1'b0, neg: 1'b0, ovf: 1'b0};
      for (int s = 1; s < NST; s++) begin
        if (s == S_P) begin
          ctl_q[s] <= ctl_p;
        end else if (s == S_A) begin
          ctl_q[s] <= ctl_a;
        end else if (s == S_DIV) begin
          ctl_q[s] <= ctl_v;
        end else begin
          ctl_q[s] <= ctl_q[s-1];
        end
      end
    end
  end

  // saturate and sign the quotient
  ctl_t             lst;
  logic [QBITS-1:0] qf;
  logic [TEMP_W-1:0] t_d;
  logic             o_d;

  assign lst = ctl_q[NST-1];
  assign qf  = qv_q[QBITS-1];

  always_comb begin
    t_d = TEMP_MIN;
    o_d = 1'b1;
    if (lst.sp) begin
      t_d = TEMP_MIN;
    end else if (lst.np) begin
      t_d = TEMP_MAX;
    end else if (lst.ovf) begin
      t_d = lst.neg ? TEMP_MIN : TEMP_MAX;
    end else if (!lst.neg) begin
      if (qf > QPOS_MAX) begin
        t_d = TEMP_MAX;
      end else begin
        t_d = TEMP_W'(qf);
        o_d = 1'b0;
      end
    end else begin
      if (qf > QNEG_MAX) begin
        t_d = TEMP_MIN;
      end else begin
        t_d = TEMP_W'(~qf + 1'b1);
        o_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= lst.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_f_sixteenths_o <= t_d;
    out_of_range_o      <= o_d;
  end

  `TBT_ASSERT_NEXT(a_start_enters, clk_i, rst_ni, start, ctl_q[0].vld)
  `TBT_ASSERT_NEXT(a_last_beat_out, clk_i, rst_ni, lst.vld, valid_o)
  `TBT_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !lst.vld, !valid_o)
  `TBT_ASSERT_NEXT(a_special_min, clk_i, rst_ni, lst.vld && lst.sp,
                   out_of_range_o && (temp_f_sixteenths_o == TEMP_MIN))
  `TBT_ASSERT_IMPLY(a_in_range, clk_i, rst_ni, valid_o && !out_of_range_o,
                    (temp_f_sixteenths_o != TEMP_W'(16384)))

endmodule
`default_nettype wire

@@ src/tbt_ln.sv @@
// Three-stage natural logarithm in Q16 by leading-one search, table and interpolation.
`default_nettype none
module tbt_ln import tbt_pkg::*; #(
  parameter int XW = RD_W + ADC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic [XW-1:0]             v_i,
  output logic [ln_width(XW)-1:0]   base_o,
  output logic [11:0]               frac_o
);

  localparam int E_W  = $clog2(XW);
  localparam int LN_W = ln_width(XW);

  logic [E_W-1:0]  e_d, e1_q, e2_q;
  logic [XW-1:0]   v1_q, norm_q;
  logic [3:0]      idx;
  logic [15:0]     rem;
  logic [11:0]     diff;
  logic [27:0]     prod;
  logic [LN_W-1:0] base_q;
  logic [11:0]     frac_q;

  // top set bit
  always_comb begin
    e_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (v_i[i]) begin
        e_d = E_W'(i);
      end
    end
  end

  assign idx  = norm_q[XW-2 -: 4];
  assign rem  = norm_q[XW-6 -: 16];
  assign diff = 12'(ln_tab({1'b0, idx} + 5'd1) - ln_tab({1'b0, idx}));
  assign prod = 28'(diff) * 28'(rem);

  always_ff @(posedge clk_i) begin
    e1_q   <= e_d;
    v1_q   <= v_i;
    e2_q   <= e1_q;
    norm_q <= v1_q << (E_W'(XW - 1) - e1_q);
    base_q <= LN_W'(e2_q) * LN_W'(LN2_Q16) + LN_W'(ln_tab({1'b0, idx}));
    frac_q <= prod[27:16];
  end

  assign base_o = base_q;
  assign frac_o = frac_q;

endmodule
`default_nettype wire

@@ verif/thermistor_beta_temperature_core_tb.sv @@
// Self-checking testbench for the Beta-equation thermistor temperature core.
`default_nettype none
module thermistor_beta_temperature_core_tb import tbt_pkg::*;;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } temp_result_t;

  localparam longint LN_TABLE [0:16] = '{
    0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
    29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426
  };
  localparam logic [11:0] FULL_SCALE = 12'hFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [11:0] adc_code_i = '0;
  logic valid_o;
  logic signed [TEMP_W-1:0] temp_f_sixteenths_o;
  logic out_of_range_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // register shadows
  logic [B_W-1:0]  beta_sh = BETA_RST;
  logic [RD_W-1:0] rdiv_sh = RDIV_RST;
  logic [RN_W-1:0] rnom_sh = RNOM_RST;
  logic [C_W-1:0]  tnom_sh = TNOM_RST;

  logic [11:0]  pending_codes[$];
  temp_result_t expected_temps[$];
  int           mismatches = 0;
  int           sender_idle_pct = 0;

  thermistor_beta_temperature_core dut (
    .clk_i, .rst_ni, .start, .busy, .adc_code_i, .valid_o,
    .temp_f_sixteenths_o, .out_of_range_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint ln_q16(input logic [63:0] v);
    int          e;
    logic [63:0] t;
    logic [19:0] frac;
    longint      lo, hi;
    e = 63;
    while (e > 0 && !v[e]) e--;
    t = v << (63 - e);
    frac = t[62:43];
    lo = LN_TABLE[frac[19:16]];
    hi = LN_TABLE[frac[19:16] + 1];
    return longint'(e) * LN2_Q16 + lo + (((hi - lo) * longint'(frac[15:0])) >>> 16);
  endfunction

  function automatic temp_result_t fahrenheit_of(input logic [11:0] code);
    temp_result_t res;
    longint b, rd, rn, c, d, n, den, num, q;
    b  = (beta_sh == 0) ? 1 : longint'(beta_sh);
    rd = (rdiv_sh == 0) ? 1 : longint'(rdiv_sh);
    rn = (rnom_sh == 0) ? 1 : longint'(rnom_sh);
    c  = longint'(tnom_sh);
    res.oor = 1'b0;
    if (code == 0 || code == FULL_SCALE) begin
      q = -8192;
      res.oor = 1'b1;
    end else begin
      d = ln_q16(rd * longint'(code)) - ln_q16(rn * longint'(FULL_SCALE - code));
      n = c * b * 65536;
      den = 100 * b * 65536 + c * d;
      if (den <= 0) begin
        q = 16383;
        res.oor = 1'b1;
      end else begin
        num = 28800 * n - 735472 * den;
        den = 1000 * den;
        if (num >= 0) q = (num + den / 2) / den;
        else q = -((-num + den / 2) / den);
        if (q > 16383) begin
          q = 16383;
          res.oor = 1'b1;
        end else if (q < -8192) begin
          q = -8192;
          res.oor = 1'b1;
        end
      end
    end
    res.temp = q[TEMP_W-1:0];
    return res;
  endfunction

  // driver: one code per beat, random gaps
  always @(negedge clk_i) begin
    if (rst_ni && pending_codes.size() > 0 &&
        $urandom_range(99) >= sender_idle_pct) begin
      start <= 1'b1;
      adc_code_i <= pending_codes.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on accepted codes, check on strobed results
  always @(posedge clk_i) begin
    temp_result_t exp_r;
    if (rst_ni && start && !busy) expected_temps.push_back(fahrenheit_of(adc_code_i));
    if (rst_ni && valid_o) begin
      if (expected_temps.size() == 0) begin
        $display("%0t: unexpected result temp=%0d oor=%0b", $time,
                 temp_f_sixteenths_o, out_of_range_o);
        mismatches++;
      end else begin
        exp_r = expected_temps.pop_front();
        if (temp_f_sixteenths_o !== exp_r.temp || out_of_range_o !== exp_r.oor) begin
          $display("%0t: expected temp=%0d oor=%0b, got temp=%0d oor=%0b", $time,
                   exp_r.temp, exp_r.oor, temp_f_sixteenths_o, out_of_range_o);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input reg_addr_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BETA: beta_sh = value[B_W-1:0];
      REG_RDIV: rdiv_sh = value[RD_W-1:0];
      REG_RNOM: rnom_sh = value[RN_W-1:0];
      REG_TNOM: tnom_sh = value[C_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (expected_temps.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] b, input logic [31:0] rd,
                           input logic [31:0] rn, input logic [31:0] c);
    write_reg(REG_BETA, b);
    write_reg(REG_RDIV, rd);
    write_reg(REG_RNOM, rn);
    write_reg(REG_TNOM, c);
  endtask

  task automatic queue_random(input int count);
    int sel;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 4) pending_codes.push_back(12'd0);
      else if (sel < 8) pending_codes.push_back(FULL_SCALE);
      else if (sel < 14) pending_codes.push_back(12'($urandom_range(15)));
      else if (sel < 20) pending_codes.push_back(FULL_SCALE - 12'($urandom_range(15)));
      else pending_codes.push_back(12'($urandom_range(4095)));
    end
  endtask

  initial begin
    logic [11:0] directed[$];
    directed = '{12'd0, 12'hFFF, 12'd1, 12'hFFE, 12'd2, 12'hFFD, 12'h800, 12'h7FF,
                 12'hAAA, 12'h555, 12'd100, 12'd1000, 12'd3000, 12'd4000,
                 12'h0F0, 12'hF0F, 12'd2047, 12'd3500, 12'd50};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values, directed codes first
    sender_idle_pct = 28;
    foreach (directed[k]) pending_codes.push_back(directed[k]);
    queue_random(190);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      sender_idle_pct = (phase < 2) ? 28 : (phase < 5) ? 49 : 0;
      case (phase)
        0: configure(1000, 100, 1000000, 20000);
        1: configure(10000, 1000000, 100, 40000);
        2: configure(0, 0, 0, 0);
        3: configure(32'h3FFF, 32'hFFFFF, 32'hFFFFF, 32'hFFFF);
        4: configure(3950, 10000, 100, 29815);
        5: configure(1000, 1000000, 1000000, 40000);
        default: configure($urandom_range(10000, 1000), $urandom_range(1000000, 100),
                           $urandom_range(1000000, 100), $urandom_range(40000, 20000));
      endcase
      foreach (directed[k]) if (k < 6) pending_codes.push_back(directed[k]);
      queue_random(185);
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/tbt_pkg.sv
src/tbt_ln.sv
src/thermistor_beta_temperature_core.sv
verif/thermistor_beta_temperature_core_tb.sv
